// ----- hdl/rrt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrt_pkg: shared types and constants for the request result tracker
// Command and lifecycle codes, field widths and the slot entry layout.
// ----------------------------------------------------------------------------
package rrt_pkg;

	localparam int ID_W    = 32;
	localparam int CMD_W   = 3;
	localparam int CODE_W  = 3;
	// reciprocal for the slot index is at most 33 bits for any slot count
	localparam int RECIP_W = ID_W + 1;
	localparam int PROD_W  = ID_W + RECIP_W;

	localparam int SLOT_COUNT_DEF = 8;

	localparam logic [ID_W-1:0] ID_ZERO = '0;
	localparam logic [ID_W-1:0] ID_ONE  = ID_W'(1);

	typedef enum logic [CMD_W-1:0] {
		CMD_NEXT_ID  = 3'd0,
		CMD_BEGIN    = 3'd1,
		CMD_CLAIM    = 3'd2,
		CMD_CANCEL   = 3'd3,
		CMD_COMPLETE = 3'd4,
		CMD_POLL     = 3'd5
	} cmd_t;

	typedef enum logic [CODE_W-1:0] {
		CODE_EMPTY    = 3'd0,
		CODE_PENDING  = 3'd1,
		CODE_ACCEPTED = 3'd2,
		CODE_REJECTED = 3'd3,
		CODE_CANCELED = 3'd4,
		CODE_CLAIMED  = 3'd5
	} code_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		code_t           code;
	} slot_entry_t;

	localparam slot_entry_t EMPTY_ENTRY = '{id: ID_ZERO, code: CODE_EMPTY};

endpackage

// ----- hdl/rrt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrt_if: request and result channels
// Valid/ready channels; a word moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface rrt_req_if;
	logic                       valid;
	logic                       ready;
	logic [rrt_pkg::CMD_W-1:0]  command;
	logic [rrt_pkg::ID_W-1:0]   request_id;
	logic                       accepted_in;

	modport source (output valid, command, request_id, accepted_in, input ready);
	modport sink   (input valid, command, request_id, accepted_in, output ready);
endinterface

interface rrt_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [rrt_pkg::ID_W-1:0]   new_id;
	logic                       success;
	logic                       finished;
	logic                       was_accepted;

	modport source (output valid, new_id, success, finished, was_accepted, input ready);
	modport sink   (input valid, new_id, success, finished, was_accepted, output ready);
endinterface

// ----- hdl/rrt_slot_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrt_slot_table: slot memory with registered read
// One read and one write port; a write to the slot being read is forwarded.
// Per-slot valid bits make unwritten slots read as empty after reset.
// ----------------------------------------------------------------------------
module rrt_slot_table #(
	parameter int SLOT_COUNT = rrt_pkg::SLOT_COUNT_DEF,
	parameter int IDX_W      = $clog2(SLOT_COUNT)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [IDX_W-1:0]     rd_idx,
	output rrt_pkg::slot_entry_t rd_data,
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_idx,
	input  rrt_pkg::slot_entry_t wr_data
);

	logic [SLOT_COUNT-1:0] valid_q;
	rrt_pkg::slot_entry_t  mem [SLOT_COUNT];
	rrt_pkg::slot_entry_t  rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			if (wr_en && (wr_idx == rd_idx)) begin
				rd_q <= wr_data;
			end else if (valid_q[rd_idx]) begin
				rd_q <= mem[rd_idx];
			end else begin
				rd_q <= rrt_pkg::EMPTY_ENTRY;
			end
		end
	end

	assign rd_data = rd_q;

endmodule

// ----- hdl/request_result_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// request_result_tracker: request lifecycle table
// Issues request ids and tracks begin/claim/cancel/complete/poll per slot.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command word (command, request_id, accepted_in); rsp
//   returns exactly one result word per command, in command order.
//   Slot = request_id mod SLOT_COUNT, found by a reciprocal multiply in the
//   input stage (no divider).
//   Pipeline: input register (_s1) -> slot memory read -> execute stage (_s2)
//   -> result register. One command per cycle sustained while rsp.ready stays
//   high; all table read-modify-writes happen in the execute stage, with the
//   write forwarded into the next read.
//   Reset: every slot reads empty with id zero (per-slot valid bits, no
//   clearing pass), the id counter restarts at one; usable the cycle after.
//   Stall: a result waiting on rsp holds; the stages behind it keep filling,
//   and req.ready drops once all three stages hold a word.
// ----------------------------------------------------------------------------
module request_result_tracker #(
	parameter int SLOT_COUNT = rrt_pkg::SLOT_COUNT_DEF
) (
	input logic       clk,
	input logic       arst_n,
	rrt_req_if.sink   req,
	rrt_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int SHIFT = rrt_pkg::ID_W + IDX_W;
	// ceil(2^SHIFT / SLOT_COUNT): exact floor quotient for any 32-bit id
	localparam logic [rrt_pkg::RECIP_W-1:0] RECIP = rrt_pkg::RECIP_W'(
		((rrt_pkg::PROD_W'(1) << SHIFT) + rrt_pkg::PROD_W'(SLOT_COUNT) - rrt_pkg::PROD_W'(1))
		/ rrt_pkg::PROD_W'(SLOT_COUNT));
	localparam logic [IDX_W-1:0] SLOT_LOW = IDX_W'(SLOT_COUNT);

	// handshake
	logic out_rdy, s2_rdy, s1_rdy;
	logic move1, fire2;

	// stage 1
	logic                        valid_s1;
	logic [rrt_pkg::CMD_W-1:0]   cmd_s1;
	logic [rrt_pkg::ID_W-1:0]    id_s1;
	logic                        acc_s1;
	logic [IDX_W-1:0]            quo_s1;
	logic [rrt_pkg::PROD_W-1:0]  prod;
	logic [IDX_W-1:0]            idx_s1;

	// stage 2
	logic                        valid_s2;
	logic [rrt_pkg::CMD_W-1:0]   cmd_s2;
	logic [rrt_pkg::ID_W-1:0]    id_s2;
	logic                        acc_s2;
	logic [IDX_W-1:0]            idx_s2;
	rrt_pkg::slot_entry_t        ent_s2;

	// execute
	logic                        id_zero, match;
	logic                        wr_en;
	rrt_pkg::slot_entry_t        wr_data;
	logic [rrt_pkg::ID_W-1:0]    new_id_d;
	logic                        success_d, finished_d, was_acc_d;

	// result and counter
	logic                        out_valid_q;
	logic [rrt_pkg::ID_W-1:0]    new_id_q;
	logic                        success_q, finished_q, was_acc_q;
	logic [rrt_pkg::ID_W-1:0]    cnt_q;

	assign out_rdy   = !out_valid_q || rsp.ready;
	assign s2_rdy    = !valid_s2 || out_rdy;
	assign s1_rdy    = !valid_s1 || s2_rdy;
	assign req.ready = s1_rdy;
	assign move1     = valid_s1 && s2_rdy;
	assign fire2     = valid_s2 && out_rdy;

	assign prod = rrt_pkg::PROD_W'(req.request_id) * rrt_pkg::PROD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_rdy) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && s1_rdy) begin
			cmd_s1 <= req.command;
			id_s1  <= req.request_id;
			acc_s1 <= req.accepted_in;
			quo_s1 <= prod[SHIFT +: IDX_W];
		end
	end

	// remainder = id - q*N, only the low index bits are needed
	assign idx_s1 = id_s1[IDX_W-1:0] - IDX_W'(quo_s1 * SLOT_LOW);

	rrt_slot_table #(
		.SLOT_COUNT (SLOT_COUNT),
		.IDX_W      (IDX_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (move1),
		.rd_idx  (idx_s1),
		.rd_data (ent_s2),
		.wr_en   (wr_en),
		.wr_idx  (idx_s2),
		.wr_data (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_rdy) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move1) begin
			cmd_s2 <= cmd_s1;
			id_s2  <= id_s1;
			acc_s2 <= acc_s1;
			idx_s2 <= idx_s1;
		end
	end

	assign id_zero = (id_s2 == rrt_pkg::ID_ZERO);
	assign match   = (ent_s2.id == id_s2);

	always_comb begin
		wr_en      = 1'b0;
		wr_data    = ent_s2;
		new_id_d   = rrt_pkg::ID_ZERO;
		success_d  = 1'b0;
		finished_d = 1'b0;
		was_acc_d  = 1'b0;
		case (cmd_s2)
			rrt_pkg::CMD_NEXT_ID: begin
				new_id_d = cnt_q;
			end
			rrt_pkg::CMD_BEGIN: begin
				if (!id_zero) begin
					wr_en        = fire2;
					wr_data.id   = id_s2;
					wr_data.code = rrt_pkg::CODE_PENDING;
				end
			end
			rrt_pkg::CMD_CLAIM: begin
				if (id_zero) begin
					success_d = 1'b1;
				end else if (match && ent_s2.code == rrt_pkg::CODE_PENDING) begin
					wr_en        = fire2;
					wr_data.code = rrt_pkg::CODE_CLAIMED;
					success_d    = 1'b1;
				end
			end
			rrt_pkg::CMD_CANCEL: begin
				if (!id_zero && match && ent_s2.code == rrt_pkg::CODE_PENDING) begin
					wr_en        = fire2;
					wr_data.code = rrt_pkg::CODE_CANCELED;
					success_d    = 1'b1;
				end
			end
			rrt_pkg::CMD_COMPLETE: begin
				if (!id_zero && match && ent_s2.code == rrt_pkg::CODE_CLAIMED) begin
					wr_en        = fire2;
					wr_data.code = acc_s2 ? rrt_pkg::CODE_ACCEPTED : rrt_pkg::CODE_REJECTED;
				end
			end
			rrt_pkg::CMD_POLL: begin
				if (match && (ent_s2.code == rrt_pkg::CODE_ACCEPTED ||
				              ent_s2.code == rrt_pkg::CODE_REJECTED)) begin
					finished_d = 1'b1;
					was_acc_d  = (ent_s2.code == rrt_pkg::CODE_ACCEPTED);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= rrt_pkg::ID_ONE;
		end else begin
			if (out_rdy) begin
				out_valid_q <= valid_s2;
			end
			// counter skips zero on wrap
			if (fire2 && cmd_s2 == rrt_pkg::CMD_NEXT_ID) begin
				cnt_q <= (cnt_q == '1) ? rrt_pkg::ID_ONE : cnt_q + rrt_pkg::ID_ONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire2) begin
			new_id_q  <= new_id_d;
			success_q <= success_d;
			finished_q <= finished_d;
			was_acc_q <= was_acc_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.new_id       = new_id_q;
	assign rsp.success      = success_q;
	assign rsp.finished     = finished_q;
	assign rsp.was_accepted = was_acc_q;

	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != rrt_pkg::ID_ZERO)
		else $error("id counter reached zero");

	a_cnt_advances: assert property (@(posedge clk) disable iff (!arst_n)
		fire2 && cmd_s2 == rrt_pkg::CMD_NEXT_ID |=> cnt_q != $past(cnt_q))
		else $error("id counter did not advance on next id");

	a_was_acc_finished: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.was_accepted |-> rsp.finished)
		else $error("was_accepted without finished");

	a_new_id_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.new_id != rrt_pkg::ID_ZERO |-> !rsp.success && !rsp.finished)
		else $error("issued id combined with other result flags");

	a_write_only_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> fire2 && !id_zero)
		else $error("table write outside an executing command");

endmodule
